// ----- design/cpps_pkg.sv -----
// Shared constants and types for the cam phase pattern sync unit.
package cpps_pkg;

	localparam int HIST_W    = 16;
	localparam int STROKE_W  = 2;
	localparam int CREDIT_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_STROKES = 4;
	localparam int WARM_W    = 3;

	typedef logic [HIST_W-1:0]    hist_t;
	typedef logic [STROKE_W-1:0]  stroke_t;
	typedef logic [CREDIT_W-1:0]  credit_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [WARM_W-1:0]    warm_cnt_t;

	// Register indexes on the configuration port
	localparam cfg_idx_t CFG_PATTERN0 = 3'd0;
	localparam cfg_idx_t CFG_PATTERN1 = 3'd1;
	localparam cfg_idx_t CFG_PATTERN2 = 3'd2;
	localparam cfg_idx_t CFG_PATTERN3 = 3'd3;
	localparam cfg_idx_t CFG_MASK     = 3'd4;

	localparam credit_t   CREDIT_RELOAD = 2'd2;
	localparam warm_cnt_t WARMUP_EDGES  = 3'd4;
	localparam logic [3:0] LOW_NIBBLE   = 4'hF;
	localparam stroke_t   STROKE_UNSYNC = 2'd1;

endpackage

// ----- design/cam_phase_pattern_sync_unit.sv -----
// Cam phase pattern sync unit: crank-edge driven cam history match and lock tracking.
//
// Usage:
//   Each request on the input channel (in_valid/in_ready, field cam_pin) is one
//   crank reference edge. A low cam pin shifts a 1 into the 16-bit history.
//   Every request yields exactly one result on the output channel
//   (out_valid/out_ready; fields synced, stroke_index, cam_history_out).
//   The result is registered and shown in the cycle after the request is taken.
//   Throughput: one request per cycle; the state update and the pattern
//   compare are a single level of logic between the state registers and the
//   result register, so the only limit is the output handshake.
//   Stall: the result register holds while out_ready is low; in_ready falls
//   only when a result is waiting and the receiver is not taking it, so a new
//   request is taken in the same cycle the waiting result leaves.
//   Reset (arst_n low, asynchronous): history, stroke, lock, miss credit,
//   warm-up count and all five configuration registers clear to zero.
//   Configuration: cfg_we/cfg_index/cfg_data writes one register per cycle;
//   indexes above the compare mask are ignored. Write only while idle.
//   Warm-up (edge count below WARMUP_EDGES after reset): no lock, credit reloaded.
module cam_phase_pattern_sync_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  cpps_pkg::cfg_idx_t      cfg_index,
	input  logic [cpps_pkg::CFG_DATA_W-1:0] cfg_data,
	// crank edge requests
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cam_pin,
	// results
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    synced,
	output cpps_pkg::stroke_t       stroke_index,
	output cpps_pkg::hist_t         cam_history_out
);
	import cpps_pkg::*;

	// configuration registers
	hist_t     pattern_q [NUM_STROKES];
	hist_t     mask_q;

	// tracking state
	hist_t     hist_q;
	stroke_t   stroke_q;
	logic      lock_q;
	credit_t   credit_q;
	warm_cnt_t warm_cnt_q;   // edge count, saturates once warm-up is over

	// result register
	logic      out_valid_q;
	logic      synced_q;
	stroke_t   stroke_out_q;
	hist_t     hist_out_q;

	// next-state logic
	logic      in_fire;
	hist_t     hist_n;
	stroke_t   stroke_n;
	warm_cnt_t warm_cnt_n;
	hist_t     diff;
	logic [3:0] low_bits;
	logic      warm;
	logic      mismatch;
	logic      lock_n;
	credit_t   credit_n;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		hist_n     = {hist_q[HIST_W-2:0], ~cam_pin};
		stroke_n   = lock_q ? stroke_q + 2'd1 : STROKE_UNSYNC;
		warm_cnt_n = (warm_cnt_q == WARMUP_EDGES) ? warm_cnt_q : warm_cnt_q + 3'd1;
		diff       = pattern_q[stroke_n] ^ hist_n;
		low_bits   = hist_n[3:0];
		warm       = warm_cnt_n < WARMUP_EDGES;
		mismatch   = (diff & mask_q) != '0;
		lock_n     = lock_q;
		credit_n   = credit_q;
		if (warm) begin
			lock_n   = 1'b0;
			credit_n = CREDIT_RELOAD;
		end else if (mismatch) begin
			// spend a credit first; drop lock only on a non-flat low nibble
			if (credit_q != '0) begin
				credit_n = credit_q - 2'd1;
			end else if (low_bits != 4'h0 && low_bits != LOW_NIBBLE) begin
				lock_n = 1'b0;
			end
		end else begin
			if ((diff[3:0] & LOW_NIBBLE) == 4'h0) begin
				lock_n = 1'b1;
			end
			credit_n = CREDIT_RELOAD;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STROKES; i++) begin
				pattern_q[i] <= '0;
			end
			mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN0: pattern_q[0] <= cfg_data;
				CFG_PATTERN1: pattern_q[1] <= cfg_data;
				CFG_PATTERN2: pattern_q[2] <= cfg_data;
				CFG_PATTERN3: pattern_q[3] <= cfg_data;
				CFG_MASK:     mask_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// tracking state advances on each accepted edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q     <= '0;
			stroke_q   <= '0;
			lock_q     <= 1'b0;
			credit_q   <= '0;
			warm_cnt_q <= '0;
		end else if (in_fire) begin
			hist_q     <= hist_n;
			stroke_q   <= stroke_n;
			lock_q     <= lock_n;
			credit_q   <= credit_n;
			warm_cnt_q <= warm_cnt_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			synced_q     <= lock_n;
			stroke_out_q <= stroke_n;
			hist_out_q   <= hist_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign synced          = synced_q;
	assign stroke_index    = stroke_out_q;
	assign cam_history_out = hist_out_q;

	// unlocked edges always report the resync stroke
	a_unsync_stroke: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !lock_q |=> stroke_index == STROKE_UNSYNC)
		else $error("stroke index not forced while unlocked");

	// no lock during warm-up
	a_warmup_nolock: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (warm_cnt_q < WARMUP_EDGES - 3'd1) |=> !synced && !lock_q)
		else $error("lock asserted during warm-up");

	// miss credit never exceeds its reload value
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CREDIT_RELOAD)
		else $error("miss credit above reload");

	// reported history is the old history shifted by one
	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> cam_history_out[HIST_W-1:1] == $past(hist_q[HIST_W-2:0]))
		else $error("history shift broken");

endmodule

// ----- sim/tb_cam_phase_pattern_sync_unit.sv -----
// Testbench for the cam phase pattern sync unit: crank edge requests against a local predictor.
`timescale 1ns / 1ps

module tb_cam_phase_pattern_sync_unit;
	import cpps_pkg::*;

	// Idle profiles for the two channels
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	// One expected result per accepted crank edge
	typedef struct packed {
		logic    synced;
		stroke_t stroke;
		hist_t   hist;
	} sync_result_t;

	localparam int STALL_LIMIT  = 2000; // cycles with no accepted request on either side
	localparam int HOLD_CYCLES  = 80;   // long receiver hold-off under pressure
	localparam int PHASE_EDGES  = 230;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic     in_valid;
	logic     in_ready;
	logic     cam_pin;
	logic     out_valid;
	logic     out_ready;
	logic     synced;
	stroke_t  stroke_index;
	hist_t    cam_history_out;

	cam_phase_pattern_sync_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cam_pin         (cam_pin),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.synced          (synced),
		.stroke_index    (stroke_index),
		.cam_history_out (cam_history_out)
	);

	// 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Pattern register names in stroke order, so computed indexes stay symbolic
	cfg_idx_t pattern_reg [NUM_STROKES] = '{CFG_PATTERN0, CFG_PATTERN1, CFG_PATTERN2,
		CFG_PATTERN3};

	logic         edge_q [$];         // crank edges (cam pin levels) waiting to be sent
	sync_result_t sync_expect_q [$];  // results predicted for accepted edges
	idle_mode_e   idle_mode = IDLE_NONE;
	int           edges_offered = 0;  // driver side
	int           edges_taken = 0;    // monitor side
	int           hold_req = 0;       // bumped to ask the receiver for a long hold-off
	int           hold_seen = 0;
	int           hold_left = 0;
	int           quiet_cycles = 0;
	int           n_fail = 0;

	// Predictor state: a shadow of the block's registers after reset
	hist_t   sh_pat [NUM_STROKES] = '{default: '0};
	hist_t   sh_mask = '0;
	hist_t   sh_hist = '0;
	stroke_t sh_stroke = '0;
	logic    sh_lock = 1'b0;
	credit_t sh_credit = '0;
	logic [15:0] sh_edges = '0;

	// Advance the shadow by one crank edge and return what the block should show.
	function automatic sync_result_t step_sync(logic pin);
		sync_result_t res;
		hist_t        diff;
		logic [3:0]   low;
		// low pin means cam bit 1, newest bit lands in bit 0
		sh_hist = {sh_hist[HIST_W-2:0], ~pin};
		if (sh_lock) begin
			sh_stroke = sh_stroke + stroke_t'(1);
		end else begin
			sh_stroke = STROKE_UNSYNC;
		end
		// saturating edge count; a wrap would re-enter warm-up
		if (sh_edges != 16'hFFFF) begin
			sh_edges = sh_edges + 16'd1;
		end
		diff = sh_pat[sh_stroke] ^ sh_hist;
		low  = sh_hist[3:0];
		if (sh_edges < 16'(WARMUP_EDGES)) begin
			sh_lock   = 1'b0;
			sh_credit = CREDIT_RELOAD;
		end else if ((diff & sh_mask) != '0) begin
			if (sh_credit != '0) begin
				sh_credit = sh_credit - credit_t'(1);
			end else if (low != 4'h0 && low != LOW_NIBBLE) begin
				// a stuck pin (low bits all equal) does not drop the lock
				sh_lock = 1'b0;
			end
		end else begin
			if (diff[3:0] == 4'h0) begin
				sh_lock = 1'b1;
			end
			sh_credit = CREDIT_RELOAD;
		end
		res.synced = sh_lock;
		res.stroke = sh_stroke;
		res.hist   = sh_hist;
		return res;
	endfunction

	function automatic int idle_pct(bit sender);
		case (idle_mode)
			IDLE_SEND: return sender ? 81 : 0;
			IDLE_RECV: return sender ? 0 : 81;
			IDLE_BOTH: return 24;
			default:   return 0;
		endcase
	endfunction

	// Driver: presents the next edge at the falling edge once the last one was taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || edges_taken == edges_offered) begin
				if (edge_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
					in_valid <= 1'b1;
					cam_pin  <= edge_q.pop_front();
					edges_offered++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a counted hold-off when pressure is requested.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
		end
	end

	// Monitor: tracks config writes, predicts on accepted edges, checks accepted results.
	always @(posedge clk) begin
		sync_result_t exp_res;
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_we) begin
				case (cfg_index)
					CFG_PATTERN0: sh_pat[0] = cfg_data;
					CFG_PATTERN1: sh_pat[1] = cfg_data;
					CFG_PATTERN2: sh_pat[2] = cfg_data;
					CFG_PATTERN3: sh_pat[3] = cfg_data;
					CFG_MASK:     sh_mask = cfg_data;
					default: ; // unused indexes are dropped
				endcase
			end
			if (out_valid && out_ready) begin
				quiet_cycles = 0;
				if (sync_expect_q.size() == 0) begin
					$error("result with no request pending: synced %0d stroke %0d hist %h",
						synced, stroke_index, cam_history_out);
					n_fail++;
				end else begin
					exp_res = sync_expect_q.pop_front();
					if (synced !== exp_res.synced) begin
						$error("synced: expected %0d, got %0d", exp_res.synced, synced);
						n_fail++;
					end
					if (stroke_index !== exp_res.stroke) begin
						$error("stroke_index: expected %0d, got %0d", exp_res.stroke,
							stroke_index);
						n_fail++;
					end
					if (cam_history_out !== exp_res.hist) begin
						$error("cam_history_out: expected %h, got %h", exp_res.hist,
							cam_history_out);
						n_fail++;
					end
				end
			end
			if (in_valid && in_ready) begin
				quiet_cycles = 0;
				sync_expect_q.push_back(step_sync(cam_pin));
				edges_taken++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_cam_phase_pattern_sync_unit: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, hist_t val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Wait until every queued edge has been sent and every result has come back.
	task automatic drain();
		while (edge_q.size() != 0 || edges_offered != edges_taken
				|| sync_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(negedge clk);
	endtask

	task automatic queue_bits(logic [15:0] pins, int n);
		@(posedge clk);
		for (int i = 0; i < n; i++) begin
			edge_q.push_back(pins[i]);
		end
	endtask

	function automatic hist_t pick_word();
		case ($urandom_range(0, 4))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h98BA;
			3:       return hist_t'($urandom) & 16'h00FF;
			default: return hist_t'($urandom);
		endcase
	endfunction

	// Well-formed cam signal: the pins repeat a random 4-bit cam word, inverted, with the
	// stroke patterns loaded as its history rotations so the block can lock and follow strokes.
	// Light bit noise and short random bursts break the sequence now and then.
	task automatic queue_cam_train(int n, int noise_pct);
		logic [3:0] cam_bits;
		int         offs;
		int         burst;
		hist_t      rot;
		logic       pin;
		cam_bits = 4'($urandom);
		offs     = $urandom_range(0, 3);
		burst    = 0;
		for (int r = 0; r < NUM_STROKES; r++) begin
			rot = '0;
			for (int j = 0; j < HIST_W; j++) begin
				rot[j] = cam_bits[(r - j + HIST_W) % 4];
			end
			write_reg(pattern_reg[(r + offs) % 4], rot);
		end
		write_reg(CFG_MASK, pick_word());
		@(posedge clk);
		for (int k = 0; k < n; k++) begin
			pin = ~cam_bits[k % 4];
			if (burst > 0) begin
				pin = 1'($urandom);
				burst--;
			end else if ($urandom_range(0, 199) == 0) begin
				burst = $urandom_range(3, 8);
			end
			if ($urandom_range(0, 99) < noise_pct) begin
				pin = ~pin;
			end
			edge_q.push_back(pin);
		end
	endtask

	// Unstructured pin levels against arbitrary patterns
	task automatic queue_cam_noise(int n);
		for (int r = 0; r < NUM_STROKES; r++) begin
			write_reg(pattern_reg[r], pick_word());
		end
		write_reg(CFG_MASK, pick_word());
		@(posedge clk);
		for (int k = 0; k < n; k++) begin
			edge_q.push_back(1'($urandom));
		end
	endtask

	initial begin
		cfg_we    = 1'b0;
		cfg_index = CFG_PATTERN0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		cam_pin   = 1'b0;
		out_ready = 1'b0;
		arst_n    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset config (patterns and mask zero): warm-up, then lock on agreement
		idle_mode = IDLE_NONE;
		queue_bits(16'b0000_0000_0001_1111, 8);
		drain();

		// Full mask against zero patterns: credits run out; a stuck-low pin keeps
		// the lock, mixed low bits drop it. Unused indexes must not touch anything.
		write_reg(CFG_MASK, 16'hFFFF);
		for (int i = CFG_MASK + 1; i < 8; i++) begin
			write_reg(cfg_idx_t'(i), 16'h1234);
		end
		queue_bits(16'b0000_0000_1101_0000, 8);
		drain();

		// Extreme patterns, constant mask
		for (int r = 0; r < NUM_STROKES; r++) begin
			write_reg(pattern_reg[r], 16'hFFFF);
		end
		write_reg(CFG_MASK, 16'h98BA);
		queue_bits(16'b0000_0000_0010_0000, 6);
		drain();

		// Random phases, cycling through the idle profiles
		for (int p = 0; p < 8; p++) begin
			idle_mode = idle_mode_e'(p % 4);
			if (p == 3 || p == 6) begin
				queue_cam_noise(PHASE_EDGES);
			end else begin
				queue_cam_train(PHASE_EDGES, $urandom_range(0, 6));
			end
			if (p == 4) begin
				// sender keeps offering while the receiver holds off
				repeat (5) @(negedge clk);
				hold_req++;
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (n_fail == 0) begin
			$display("tb_cam_phase_pattern_sync_unit: PASS");
		end else begin
			$display("tb_cam_phase_pattern_sync_unit: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/cpps_pkg.sv
design/cam_phase_pattern_sync_unit.sv
sim/tb_cam_phase_pattern_sync_unit.sv
